### rtl/tpsc_pkg.sv
// Shared types and constants for the two-point sensor calibration core.
// Used by every module of the block; depends on nothing.
package tpsc_pkg;

   localparam int SampleWidth = 24;
   localparam int FullScale   = 10000;
   localparam int QuotWidth   = 14;                    // quotient stays below 2**14
   localparam int DenWidth    = SampleWidth + 1;       // 2*d
   localparam int ProdWidth   = SampleWidth + 15;      // n * 2*FullScale
   localparam int NumCells    = QuotWidth;
   localparam int FrontStages = 3;
   localparam int Latency     = FrontStages + NumCells + 1;
   localparam int AddrWidth   = 4;

   localparam logic [14:0] TwiceScale = 15'(2 * FullScale);

   typedef enum logic [1:0] {
      REG_ZERO_POINT = 2'd0,
      REG_FULL_POINT = 2'd1,
      REG_ENABLE     = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_RAW  = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_FULL = 2'd2,
      KIND_DIV  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [SampleWidth-1:0] zero_point;
      logic [SampleWidth-1:0] full_point;
      logic                   enable;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [SampleWidth-1:0] raw;
      logic [DenWidth-1:0]    rem;
      logic [QuotWidth-1:0]   num_low;
      logic [QuotWidth-1:0]   quot;
      logic [DenWidth-1:0]    den;
   } lane_type;

endpackage

### rtl/tpsc_csr.sv
// Configuration registers behind the APB-style port.
// Depends on tpsc_pkg.
module tpsc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tpsc_pkg::AddrWidth-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output tpsc_pkg::cfg_type                 cfg
);

   tpsc_pkg::cfg_type cfg_ff, cfg_in;
   tpsc_pkg::reg_index_type idx;
   logic wr_en;

   assign idx    = tpsc_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            tpsc_pkg::REG_ZERO_POINT: cfg_in.zero_point = pwdata[23:0];
            tpsc_pkg::REG_FULL_POINT: cfg_in.full_point = pwdata[23:0];
            tpsc_pkg::REG_ENABLE:     cfg_in.enable     = pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         tpsc_pkg::REG_ZERO_POINT: prdata = {8'd0, cfg_ff.zero_point};
         tpsc_pkg::REG_FULL_POINT: prdata = {8'd0, cfg_ff.full_point};
         tpsc_pkg::REG_ENABLE:     prdata = {31'd0, cfg_ff.enable};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/tpsc_front.sv
// Front stages: signed differences, clamp classification, scaling multiply and
// dividend setup for the divider cell chain. Depends on tpsc_pkg.
module tpsc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [tpsc_pkg::SampleWidth-1:0]     raw_sample,
   input  tpsc_pkg::cfg_type                    cfg,
   output tpsc_pkg::lane_type                   lane
);

   localparam int W = tpsc_pkg::SampleWidth;

   // stage 1: differences, sign of the denominator folded in
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_active_ff, s1_active_in;
   logic [W-1:0]         s1_raw_ff;
   logic signed [W+1:0]  s1_n_ff, s1_n_in;
   logic [W-1:0]         s1_d_ff, s1_d_in;

   // stage 2: classification and product
   logic                          s2_valid_ff;
   tpsc_pkg::kind_type            s2_kind_ff, s2_kind_in;
   logic [W-1:0]                  s2_raw_ff;
   logic [tpsc_pkg::ProdWidth-1:0] s2_prod_ff, s2_prod_in;
   logic [W-1:0]                  s2_d_ff;

   // stage 3: dividend and divisor for the cell chain
   tpsc_pkg::lane_type            s3_ff, s3_in;

   logic signed [W+1:0] sz, sf, ss, n_pos, n_neg, d_pos, d_neg;
   logic [tpsc_pkg::ProdWidth-1:0] dividend;

   always_comb begin
      sz = (W+2)'(signed'(cfg.zero_point));
      sf = (W+2)'(signed'(cfg.full_point));
      ss = (W+2)'(signed'(raw_sample));
      n_pos = ss - sz;
      n_neg = sz - ss;
      d_pos = sf - sz;
      d_neg = sz - sf;
      s1_valid_in  = accept;
      s1_active_in = cfg.enable && (cfg.zero_point != cfg.full_point);
      s1_n_in = d_pos[W+1] ? n_neg : n_pos;
      s1_d_in = d_pos[W+1] ? d_neg[W-1:0] : d_pos[W-1:0];
   end

   always_comb begin
      if (!s1_active_ff) begin
         s2_kind_in = tpsc_pkg::KIND_RAW;
      end else if (s1_n_ff <= 0) begin
         s2_kind_in = tpsc_pkg::KIND_ZERO;
      end else if (s1_n_ff >= signed'({2'b00, s1_d_ff})) begin
         s2_kind_in = tpsc_pkg::KIND_FULL;
      end else begin
         s2_kind_in = tpsc_pkg::KIND_DIV;
      end
      s2_prod_in = tpsc_pkg::ProdWidth'(s1_n_ff[W-1:0]) *
                   tpsc_pkg::ProdWidth'(tpsc_pkg::TwiceScale);
   end

   always_comb begin
      dividend        = s2_prod_ff + tpsc_pkg::ProdWidth'(s2_d_ff);
      s3_in.valid     = s2_valid_ff;
      s3_in.kind      = s2_kind_ff;
      s3_in.raw       = s2_raw_ff;
      // quotient fits in QuotWidth bits, so the upper part is already below the divisor
      s3_in.rem       = dividend[tpsc_pkg::ProdWidth-1:tpsc_pkg::QuotWidth];
      s3_in.num_low   = dividend[tpsc_pkg::QuotWidth-1:0];
      s3_in.quot      = '0;
      s3_in.den       = {s2_d_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s3_in.valid;
      end
      s1_active_ff  <= s1_active_in;
      s1_raw_ff     <= raw_sample;
      s1_n_ff       <= s1_n_in;
      s1_d_ff       <= s1_d_in;
      s2_kind_ff    <= s2_kind_in;
      s2_raw_ff     <= s1_raw_ff;
      s2_prod_ff    <= s2_prod_in;
      s2_d_ff       <= s1_d_ff;
      s3_ff.kind    <= s3_in.kind;
      s3_ff.raw     <= s3_in.raw;
      s3_ff.rem     <= s3_in.rem;
      s3_ff.num_low <= s3_in.num_low;
      s3_ff.quot    <= s3_in.quot;
      s3_ff.den     <= s3_in.den;
   end

   assign lane = s3_ff;

endmodule

### rtl/tpsc_cell.sv
// One restoring-division cell: produces one quotient bit per transaction and
// hands the lane to the next cell every cycle. Depends on tpsc_pkg.
module tpsc_cell (
   input  logic                clock,
   input  logic                reset,
   input  tpsc_pkg::lane_type  lane_i,
   output tpsc_pkg::lane_type  lane_o
);

   localparam int DW = tpsc_pkg::DenWidth;
   localparam int QW = tpsc_pkg::QuotWidth;

   tpsc_pkg::lane_type lane_ff, lane_in;
   logic [DW:0] trial;
   logic [DW:0] diff;
   logic        ge;

   always_comb begin
      trial = {lane_i.rem, lane_i.num_low[QW-1]};
      diff  = trial - {1'b0, lane_i.den};
      ge    = trial >= {1'b0, lane_i.den};
      lane_in         = lane_i;
      lane_in.rem     = ge ? diff[DW-1:0] : trial[DW-1:0];
      lane_in.num_low = {lane_i.num_low[QW-2:0], 1'b0};
      lane_in.quot    = {lane_i.quot[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in.valid;
      end
      lane_ff.kind    <= lane_in.kind;
      lane_ff.raw     <= lane_in.raw;
      lane_ff.rem     <= lane_in.rem;
      lane_ff.num_low <= lane_in.num_low;
      lane_ff.quot    <= lane_in.quot;
      lane_ff.den     <= lane_in.den;
   end

   assign lane_o = lane_ff;

endmodule

### rtl/two_point_sensor_calibration_core.sv
// Top level of the two-point sensor calibration core: register port, front
// stages, divider cell chain and result register. Depends on tpsc_pkg and all tpsc_* modules.
//
//   channel   direction  handshake                      payload
//   request   in         start (accepted when !busy)    req_raw_sample
//   response  out        rsp_valid, one-cycle strobe    rsp_out_value, rsp_is_calibrated
//   config    in/out     psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One transaction per cycle; busy is always low. After its request is accepted,
// each result passes through three front stages, one divider cell per
// quotient bit (14), and the result register. Pass-through samples take the
// same path, so order is kept. Reset clears the valid flags and config, emptying the pipe.
// The receiver cannot stall; results are never held.
module two_point_sensor_calibration_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tpsc_pkg::SampleWidth-1:0]     req_raw_sample,
   output logic                                 rsp_valid,
   output logic [tpsc_pkg::SampleWidth-1:0]     rsp_out_value,
   output logic                                 rsp_is_calibrated,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tpsc_pkg::AddrWidth-1:0]       paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int NC = tpsc_pkg::NumCells;
   localparam int W  = tpsc_pkg::SampleWidth;

   tpsc_pkg::cfg_type  cfg;
   tpsc_pkg::lane_type lanes [NC+1];

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_value_ff, rsp_value_in;
   logic         rsp_cal_ff, rsp_cal_in;

   assign busy = 1'b0;

   tpsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (start & ~busy),
      .raw_sample (req_raw_sample),
      .cfg        (cfg),
      .lane       (lanes[0])
   );

   for (genvar i = 0; i < NC; i++) begin : g_cell
      tpsc_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (lanes[i]),
         .lane_o (lanes[i+1])
      );
   end

   always_comb begin
      rsp_valid_in = lanes[NC].valid;
      rsp_cal_in   = lanes[NC].kind != tpsc_pkg::KIND_RAW;
      case (lanes[NC].kind)
         tpsc_pkg::KIND_RAW:  rsp_value_in = lanes[NC].raw;
         tpsc_pkg::KIND_ZERO: rsp_value_in = '0;
         tpsc_pkg::KIND_FULL: rsp_value_in = W'(tpsc_pkg::FullScale);
         tpsc_pkg::KIND_DIV:  rsp_value_in = W'(lanes[NC].quot);
         default:             rsp_value_in = lanes[NC].raw;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_cal_ff   <= rsp_cal_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_is_calibrated = rsp_cal_ff;

   // every accepted transaction yields a result at the end of the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(tpsc_pkg::Latency) rsp_valid)
      else $error("result missing after accepted transaction");

   // calibrated results never exceed full scale
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_calibrated |-> rsp_out_value <= W'(tpsc_pkg::FullScale))
      else $error("calibrated result above full scale");

   // pass-through results carry the sample that entered
   a_passthru: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_calibrated |->
         rsp_out_value == $past(req_raw_sample, tpsc_pkg::Latency))
      else $error("pass-through value corrupted");

endmodule

### tb/sv/tpsc_calib_checker.sv
`timescale 1ns / 1ps
// Checker for the two-point sensor calibration core: tracks register writes,
// predicts each reading, calibrated or passed through, and compares it with the response strobe.
// Depends on tpsc_pkg for widths, full scale and register indexes.
module tpsc_calib_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [tpsc_pkg::SampleWidth-1:0] req_raw_sample,
   input  logic                             rsp_valid,
   input  logic [tpsc_pkg::SampleWidth-1:0] rsp_out_value,
   input  logic                             rsp_is_calibrated,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tpsc_pkg::AddrWidth-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   input  logic                             pready,
   output int                               fail_count,
   output int                               outstanding
);
   import tpsc_pkg::*;

   typedef struct packed {
      logic [SampleWidth-1:0] value;
      logic                   calibrated;
   } reading_type;

   logic [SampleWidth-1:0] zero_point = '0;
   logic [SampleWidth-1:0] full_point = '0;
   logic                   cal_enable = 1'b0;

   reading_type readings_due[$];
   int          mismatches = 0;
   int          due_count  = 0;

   assign fail_count  = mismatches;
   assign outstanding = due_count;

   // Percent times 100 from the two calibration points, rounded half up.
   function automatic reading_type calibrate_reading(input logic [SampleWidth-1:0] zero,
                                                     input logic [SampleWidth-1:0] full,
                                                     input logic enable,
                                                     input logic [SampleWidth-1:0] raw);
      reading_type res;
      longint z;
      longint f;
      longint s;
      longint num;
      longint den;
      res.value      = raw;
      res.calibrated = 1'b0;
      if (!enable || (zero == '0 && full == '0) || zero == full)
         return res;
      z   = $signed(zero);
      f   = $signed(full);
      s   = $signed(raw);
      num = s - z;
      den = f - z;
      // flip both when the full point lies below the zero point
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      res.calibrated = 1'b1;
      if (num <= 0)
         res.value = '0;
      else if (num >= den)
         res.value = SampleWidth'(FullScale);
      else
         res.value = SampleWidth'((num * 2 * FullScale + den) / (2 * den));
      return res;
   endfunction

   always @(posedge clock) begin
      reading_type due;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_ZERO_POINT: zero_point = pwdata[SampleWidth-1:0];
               REG_FULL_POINT: full_point = pwdata[SampleWidth-1:0];
               REG_ENABLE:     cal_enable = pwdata[0];
               default: ;
            endcase
         end
         if (start && !busy)
            readings_due.push_back(calibrate_reading(zero_point, full_point, cal_enable,
                                                     req_raw_sample));
         if (rsp_valid) begin
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response value=%06h calibrated=%0b", $realtime,
                           rsp_out_value, rsp_is_calibrated);
            end else begin
               due = readings_due.pop_front();
               if (rsp_out_value !== due.value || rsp_is_calibrated !== due.calibrated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch value exp=%06h got=%06h calibrated exp=%0b got=%0b",
                              $realtime, due.value, rsp_out_value, due.calibrated,
                              rsp_is_calibrated);
               end
            end
         end
         due_count = readings_due.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the calibration core testbench: clock, reset, sample and register
// stimulus, watchdog and verdict. Depends on tpsc_pkg, the core and tpsc_calib_checker.
module tb_top;
   import tpsc_pkg::*;

   localparam int         WatchdogLimit = 1000;
   localparam int         RandomItems   = 1850;
   localparam logic [1:0] RegUnused     = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [SampleWidth-1:0] req_raw_sample = '0;
   logic                   rsp_valid;
   logic [SampleWidth-1:0] rsp_out_value;
   logic                   rsp_is_calibrated;
   logic                   psel    = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite  = 1'b0;
   logic [AddrWidth-1:0]   paddr   = '0;
   logic [31:0]            pwdata  = '0;
   logic [31:0]            prdata;
   logic                   pready;

   int fail_count;
   int outstanding;
   int stall_cycles = 0;
   int burst_left   = 0;

   // stimulus copy of the points, used only to aim samples
   logic [SampleWidth-1:0] cur_zero = '0;
   logic [SampleWidth-1:0] cur_full = '0;

   two_point_sensor_calibration_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_raw_sample    (req_raw_sample),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_is_calibrated (rsp_is_calibrated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   tpsc_calib_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_raw_sample    (req_raw_sample),
      .rsp_valid         (rsp_valid),
      .rsp_out_value     (rsp_out_value),
      .rsp_is_calibrated (rsp_is_calibrated),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WatchdogLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_points(input logic [31:0] zero_word, input logic [31:0] full_word,
                             input logic [31:0] enable_word);
      csr_write(REG_ZERO_POINT, zero_word);
      csr_write(REG_FULL_POINT, full_word);
      csr_write(REG_ENABLE, enable_word);
      cur_zero = zero_word[SampleWidth-1:0];
      cur_full = full_word[SampleWidth-1:0];
   endtask

   // hold start until the transaction is taken
   task automatic send_sample(input logic [SampleWidth-1:0] raw);
      start          <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [SampleWidth-1:0] pick_sample();
      longint z;
      longint f;
      longint lo;
      longint hi;
      longint margin;
      int     mode;
      z    = $signed(cur_zero);
      f    = $signed(cur_full);
      lo   = (z < f) ? z : f;
      hi   = (z < f) ? f : z;
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
         margin = (hi - lo) / 8 + 2;
         return SampleWidth'(lo - margin + longint'($urandom_range(0, 32'(hi - lo + 2 * margin))));
      end
      if (mode <= 6)
         return SampleWidth'($urandom);
      case ($urandom_range(0, 7))
         0: return cur_zero;
         1: return cur_full;
         2: return cur_zero - 1'b1;
         3: return cur_zero + 1'b1;
         4: return cur_full - 1'b1;
         5: return cur_full + 1'b1;
         6: return {1'b1, {(SampleWidth-1){1'b0}}};
         default: return {1'b0, {(SampleWidth-1){1'b1}}};
      endcase
   endfunction

   function automatic logic [SampleWidth-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(SampleWidth-1){1'b0}}};
         default: return {1'b0, {(SampleWidth-1){1'b1}}};
      endcase
   endfunction

   task automatic random_setup();
      logic [31:0] zero_word;
      logic [31:0] full_word;
      logic [31:0] enable_word;
      zero_word   = $urandom;
      full_word   = $urandom;
      enable_word = 32'($urandom_range(0, 7) != 0) | ($urandom & 32'hFFFF_FFFE);
      case ($urandom_range(0, 7))
         1: full_word = zero_word + $urandom_range(1, 4);
         2: begin
            zero_word = 32'(pick_extreme());
            full_word = 32'(pick_extreme());
         end
         3: enable_word = 32'h0;
         4: full_word = zero_word;
         5: full_word = zero_word - $urandom_range(1, 200000);
         6: if ($urandom_range(0, 1)) zero_word = '0; else full_word = '0;
         default: ;
      endcase
      set_points(zero_word, full_word, enable_word);
   endtask

   task automatic run_phase(input int count);
      int gap;
      repeat (count) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 15) == 0)
               wait_drained();
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         send_sample(pick_sample());
         burst_left--;
      end
      wait_drained();
   endtask

   initial begin
      int sent;
      int phase_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // after reset calibration is off: pass everything through
      send_sample('0);
      send_sample('1);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      wait_drained();

      // span of 20000 counts puts odd offsets exactly on a rounding half
      set_points(32'h0000_0100, 32'h0000_4F20, 32'h1);
      csr_write(RegUnused, 32'hFFFF_FFFF);
      send_sample(24'h0000FF);
      send_sample(24'h000100);
      send_sample(24'h000101);
      send_sample(24'h000103);
      send_sample(24'h004F20);
      send_sample(24'h004F21);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      wait_drained();

      // full point below zero point, widest possible span
      set_points(32'h007F_FFFF, 32'h0080_0000, 32'h1);
      send_sample('0);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample('1);
      wait_drained();

      // equal points, then both points zero: calibration stays off
      set_points(32'h0012_3456, 32'h0012_3456, 32'h1);
      send_sample(24'h123456);
      wait_drained();
      set_points(32'h0, 32'h0, 32'h1);
      send_sample(24'hABCDEF);
      wait_drained();

      // upper write bits must be dropped
      set_points(32'hFF00_0005, 32'hA5FF_FFF0, 32'h8000_0003);
      send_sample('0);
      send_sample(24'hFFFFF8);
      wait_drained();

      sent = 0;
      while (sent < RandomItems) begin
         random_setup();
         phase_len = $urandom_range(80, 180);
         if (phase_len > RandomItems - sent)
            phase_len = RandomItems - sent;
         run_phase(phase_len);
         sent += phase_len;
      end

      repeat (Latency + 4) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### two_point_sensor_calibration_core.f
rtl/tpsc_pkg.sv
rtl/tpsc_csr.sv
rtl/tpsc_front.sv
rtl/tpsc_cell.sv
rtl/two_point_sensor_calibration_core.sv
tb/sv/tpsc_calib_checker.sv
tb/sv/tb_top.sv
